>>> src/rkdh_pkg.sv
// ----------------------------------------------------------------------------
// rkdh_pkg
// Shared types and codes of the running k-th smallest dual heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rkdh_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned RANK_W   = 11;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd2;

  typedef enum logic {
    HOP_PUSH,
    HOP_POP
  } heap_op_e;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP_CHK,
    H_UP_CMP,
    H_DN_LD,
    H_DN_CHK,
    H_DN_CMP
  } heap_state_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_ADD_W,
    T_ADD_CHK,
    T_GET_CHK,
    T_MV_PUSH,
    T_MV_PUSH_W,
    T_MV_POP,
    T_MV_POP_W,
    T_OUT
  } top_state_e;

  // request from the sequencer to one heap engine
  typedef struct packed {
    logic                     start;
    logic                     clear;
    heap_op_e                 op;
    logic signed [DATA_W-1:0] value;
  } heap_req_t;

  // response of one heap engine
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] top;
  } heap_rsp_t;

endpackage

`default_nettype wire

>>> src/running_kth_smallest_dual_heap_unit.sv
// ----------------------------------------------------------------------------
// running_kth_smallest_dual_heap_unit
// Running rank-th smallest value over a multiset held as a max-heap below a
// middle value and a min-heap at or above it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | func_i, value_i
//  out     | output    | out_valid_o/out_stall_i | kth_value_o, rank_o, status_o
//
//  One transaction at a time. Clear, seed, dropped add and refused get go
//  straight to the output state; an add pushes into one heap; a move
//  between heaps is a push plus a pop, each walking the tree level by
//  level through the read-compare-write loop on its heap RAM.
//  Reset empties both heaps at once by clearing their counts; no sweep.
//  A finished result waits in the output register while the next input
//  transaction is accepted; the block stalls input whenever a transaction
//  is in progress, also while its result waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module running_kth_smallest_dual_heap_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [rkdh_pkg::FUNC_W-1:0]         func_i,
  input  wire logic signed [rkdh_pkg::DATA_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [rkdh_pkg::DATA_W-1:0]       kth_value_o,
  output logic [rkdh_pkg::RANK_W-1:0]              rank_o,
  output logic [rkdh_pkg::STATUS_W-1:0]            status_o
);

  import rkdh_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  top_state_e               state_q, state_d;
  logic signed [DATA_W-1:0] middle_q, middle_d;
  logic                     mid_valid_q, mid_valid_d;
  logic [CW-1:0]            rank_q, rank_d;
  logic                     dir_up_q, dir_up_d;
  logic                     lo_add_q, lo_add_d;
  logic signed [DATA_W-1:0] kth_q, kth_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_kth_q, out_kth_d;
  logic [RANK_W-1:0]        out_rank_q, out_rank_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;

  heap_req_t                lo_req, up_req;
  heap_rsp_t                lo_rsp, up_rsp;
  logic [CW-1:0]            lo_cnt, up_cnt;

  logic [CW:0]              total, rank_p1;
  logic                     accept, add_full, add_lower, get_few;
  logic                     dst_done, src_done, add_done;
  logic signed [DATA_W-1:0] src_top;
  logic [CW+RANK_W-1:0]     rank_ext;

  rkdh_heap #(
    .CAPACITY (CAPACITY),
    .IS_MAX   (1'b1)
  ) u_lower (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lo_req),
    .rsp_o   (lo_rsp),
    .count_o (lo_cnt)
  );

  rkdh_heap #(
    .CAPACITY (CAPACITY),
    .IS_MAX   (1'b0)
  ) u_upper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (up_req),
    .rsp_o   (up_rsp),
    .count_o (up_cnt)
  );

  // occupancy and decisions
  always_comb begin
    accept    = in_valid_i && (state_q == T_IDLE);
    total     = {1'b0, lo_cnt} + {1'b0, up_cnt} + (CW+1)'(mid_valid_q);
    rank_p1   = {1'b0, rank_q} + (CW+1)'(1);
    add_full  = total >= (CW+1)'(CAPACITY);
    add_lower = value_i < middle_q;
    get_few   = !mid_valid_q || (total < rank_p1);
    dst_done  = dir_up_q ? up_rsp.done : lo_rsp.done;
    src_done  = dir_up_q ? lo_rsp.done : up_rsp.done;
    src_top   = dir_up_q ? lo_rsp.top : up_rsp.top;
    add_done  = lo_add_q ? lo_rsp.done : up_rsp.done;
    rank_ext  = {{RANK_W{1'b0}}, rank_q};
  end

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    middle_d     = middle_q;
    mid_valid_d  = mid_valid_q;
    rank_d       = rank_q;
    dir_up_d     = dir_up_q;
    lo_add_d     = lo_add_q;
    kth_d        = kth_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_kth_d    = out_kth_q;
    out_rank_d   = out_rank_q;
    out_status_d = out_status_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          kth_d    = '0;
          status_d = STATUS_OK;
          state_d  = T_OUT;
          case (func_i)
            FUNC_ADD: begin
              if (add_full) begin
                status_d = STATUS_FULL;
              end else if (!mid_valid_q) begin
                middle_d    = value_i;
                mid_valid_d = 1'b1;
              end else begin
                lo_add_d = add_lower;
                state_d  = T_ADD_W;
              end
            end
            FUNC_GET: begin
              if (get_few) begin
                status_d = STATUS_FEW;
              end else begin
                state_d = T_GET_CHK;
              end
            end
            FUNC_CLEAR: begin
              middle_d    = '0;
              mid_valid_d = 1'b0;
              rank_d      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      T_ADD_W: begin
        if (add_done) begin
          state_d = lo_add_q ? T_ADD_CHK : T_OUT;
        end
      end
      T_ADD_CHK: begin
        if ((lo_cnt != '0) && ({1'b0, lo_cnt} >= rank_p1)) begin
          dir_up_d = 1'b1;
          state_d  = T_MV_PUSH;
        end else begin
          state_d = T_OUT;
        end
      end
      T_GET_CHK: begin
        if ((lo_cnt < rank_q) && (up_cnt != '0)) begin
          dir_up_d = 1'b0;
          state_d  = T_MV_PUSH;
        end else begin
          rank_d  = rank_p1[CW-1:0];
          kth_d   = middle_q;
          state_d = T_OUT;
        end
      end
      T_MV_PUSH: state_d = T_MV_PUSH_W;
      T_MV_PUSH_W: begin
        if (dst_done) begin
          state_d = T_MV_POP;
        end
      end
      T_MV_POP: state_d = T_MV_POP_W;
      T_MV_POP_W: begin
        if (src_done) begin
          middle_d = src_top;
          state_d  = dir_up_q ? T_ADD_CHK : T_GET_CHK;
        end
      end
      T_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_kth_d    = kth_q;
          out_rank_d   = rank_ext[RANK_W-1:0];
          out_status_d = status_q;
          state_d      = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // heap requests and input stall
  always_comb begin
    lo_req     = '{start: 1'b0, clear: 1'b0, op: HOP_PUSH, value: value_i};
    up_req     = '{start: 1'b0, clear: 1'b0, op: HOP_PUSH, value: value_i};
    in_stall_o = (state_q != T_IDLE);
    case (state_q)
      T_IDLE: begin
        if (accept && (func_i == FUNC_ADD) && !add_full && mid_valid_q) begin
          lo_req.start = add_lower;
          up_req.start = !add_lower;
        end
        if (accept && (func_i == FUNC_CLEAR)) begin
          lo_req.clear = 1'b1;
          up_req.clear = 1'b1;
        end
      end
      T_MV_PUSH: begin
        lo_req.value = middle_q;
        up_req.value = middle_q;
        lo_req.start = !dir_up_q;
        up_req.start = dir_up_q;
      end
      T_MV_POP: begin
        lo_req.op    = HOP_POP;
        up_req.op    = HOP_POP;
        lo_req.start = dir_up_q;
        up_req.start = !dir_up_q;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      middle_q    <= '0;
      mid_valid_q <= 1'b0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      middle_q    <= middle_d;
      mid_valid_q <= mid_valid_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dir_up_q     <= dir_up_d;
    lo_add_q     <= lo_add_d;
    kth_q        <= kth_d;
    status_q     <= status_d;
    out_kth_q    <= out_kth_d;
    out_rank_q   <= out_rank_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = out_kth_q;
  assign rank_o      = out_rank_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

>>> src/rkdh_ram.sv
// ----------------------------------------------------------------------------
// rkdh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rkdh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> src/rkdh_heap.sv
// ----------------------------------------------------------------------------
// rkdh_heap
// Binary heap in one RAM with push (sift up) and pop (sift down) engines.
// ----------------------------------------------------------------------------
`default_nettype none

module rkdh_heap #(
  parameter int unsigned CAPACITY = 1024,
  parameter bit          IS_MAX   = 1'b0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rkdh_pkg::heap_req_t          req_i,
  output rkdh_pkg::heap_rsp_t               rsp_o,
  output logic [$clog2(CAPACITY+1)-1:0]     count_o
);

  import rkdh_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  heap_state_e              state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] top_q, top_d;

  logic                     we;
  logic [IW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic [IW-1:0]            raddr_a, raddr_b;
  logic [DATA_W-1:0]        rdata_a, rdata_b;
  logic signed [DATA_W-1:0] ra_val, rb_val;

  logic [CW:0]              left_w, right_w, cnt_x, child_w;
  logic [CW-1:0]            parent_w, cnt_m1;
  logic                     pick_r;
  logic signed [DATA_W-1:0] child_val;

  function automatic logic goes_first(input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b);
    return IS_MAX ? (a > b) : (a < b);
  endfunction

  rkdh_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // index arithmetic and child selection
  always_comb begin
    ra_val    = signed'(rdata_a);
    rb_val    = signed'(rdata_b);
    left_w    = {idx_q, 1'b0} + (CW+1)'(1);
    right_w   = left_w + (CW+1)'(1);
    cnt_x     = {1'b0, cnt_q};
    parent_w  = (idx_q - CW'(1)) >> 1;
    cnt_m1    = cnt_q - CW'(1);
    pick_r    = (right_w < cnt_x) && goes_first(rb_val, ra_val);
    child_val = pick_r ? rb_val : ra_val;
    child_w   = pick_r ? right_w : left_w;
  end

  // next state and datapath
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    x_d     = x_q;
    top_d   = top_q;
    case (state_q)
      H_IDLE: begin
        if (req_i.clear) begin
          cnt_d = '0;
        end else if (req_i.start) begin
          if (req_i.op == HOP_PUSH) begin
            x_d     = req_i.value;
            idx_d   = cnt_q;
            cnt_d   = cnt_q + CW'(1);
            state_d = H_UP_CHK;
          end else begin
            cnt_d   = cnt_m1;
            state_d = H_DN_LD;
          end
        end
      end
      H_UP_CHK: begin
        state_d = (idx_q == '0) ? H_IDLE : H_UP_CMP;
      end
      H_UP_CMP: begin
        if (goes_first(x_q, ra_val)) begin
          idx_d   = parent_w;
          state_d = H_UP_CHK;
        end else begin
          state_d = H_IDLE;
        end
      end
      H_DN_LD: begin
        top_d   = ra_val;
        x_d     = rb_val;
        idx_d   = '0;
        state_d = H_DN_CHK;
      end
      H_DN_CHK: begin
        state_d = (left_w >= cnt_x) ? H_IDLE : H_DN_CMP;
      end
      H_DN_CMP: begin
        if (goes_first(child_val, x_q)) begin
          idx_d   = child_w[CW-1:0];
          state_d = H_DN_CHK;
        end else begin
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  // memory controls and done
  always_comb begin
    we         = 1'b0;
    waddr      = idx_q[IW-1:0];
    wdata      = x_q;
    raddr_a    = '0;
    raddr_b    = cnt_m1[IW-1:0];
    rsp_o.done = 1'b0;
    rsp_o.top  = top_q;
    case (state_q)
      H_UP_CHK: begin
        if (idx_q == '0) begin
          we         = 1'b1;
          rsp_o.done = 1'b1;
        end else begin
          raddr_a = parent_w[IW-1:0];
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (goes_first(x_q, ra_val)) begin
          wdata = ra_val;
        end else begin
          rsp_o.done = 1'b1;
        end
      end
      H_DN_CHK: begin
        if (left_w >= cnt_x) begin
          we         = 1'b1;
          rsp_o.done = 1'b1;
        end else begin
          raddr_a = left_w[IW-1:0];
          raddr_b = right_w[IW-1:0];
        end
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (goes_first(child_val, x_q)) begin
          wdata = child_val;
        end else begin
          rsp_o.done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_o = cnt_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    x_q   <= x_d;
    top_q <= top_d;
  end

endmodule

`default_nettype wire

>>> src/rkdh_checker.sv
// ----------------------------------------------------------------------------
// rkdh_checker
// Port-level checks of the running k-th smallest dual heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rkdh_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic [rkdh_pkg::FUNC_W-1:0]         func_i,
  input wire logic signed [rkdh_pkg::DATA_W-1:0]  value_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic signed [rkdh_pkg::DATA_W-1:0]  kth_value_o,
  input wire logic [rkdh_pkg::RANK_W-1:0]         rank_o,
  input wire logic [rkdh_pkg::STATUS_W-1:0]       status_o
);

  import rkdh_pkg::*;

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a refused or dropped transaction carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> kth_value_o == '0)
    else $error("nonzero value on error status");

  // a returned value comes only from a good get, so the rank has moved
  a_kth_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kth_value_o != '0) |-> (status_o == STATUS_OK) && (rank_o != '0))
    else $error("value returned without a rank");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(kth_value_o) && $stable(rank_o) && $stable(status_o))
    else $error("result changed while stalled");

endmodule

bind running_kth_smallest_dual_heap_unit rkdh_checker u_checker (.*);

`default_nettype wire

>>> tb/running_kth_smallest_dual_heap_unit_tb.sv
// ----------------------------------------------------------------------------
// running_kth_smallest_dual_heap_unit_tb
// Drives add, get and clear transactions into the dual heap unit, predicts
// each result with a behavioral copy of the heaps and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_kth_smallest_dual_heap_unit_tb;
  import rkdh_pkg::*;

  localparam int unsigned CAP       = 1024;
  localparam int          STALL_CAP = 2000;
  localparam int          TIMEOUT   = 20000;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth;
    logic [RANK_W-1:0]        rnk;
    logic [STATUS_W-1:0]      st;
  } result_t;

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    result_t                  res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FUNC_W-1:0] func_i = FUNC_ADD;
  logic signed [DATA_W-1:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] kth_value_o;
  logic [RANK_W-1:0] rank_o;
  logic [STATUS_W-1:0] status_o;

  running_kth_smallest_dual_heap_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .value_i,
    .out_valid_o, .out_stall_i, .kth_value_o, .rank_o, .status_o
  );

  always #4 clk_i = ~clk_i;

  // predicted multiset state
  logic signed [DATA_W-1:0] lo_heap[CAP];
  logic signed [DATA_W-1:0] up_heap[CAP];
  logic signed [DATA_W-1:0] mid_val;
  bit                       mid_ok;
  int unsigned              lo_cnt, up_cnt, rank_cnt;

  result_t pending_q[$];
  int      mismatches = 0;
  int      send_idle_pct = 0, recv_stall_pct = 0;
  bit      hold_recv = 1'b0;
  int      idle_cycles = 0;

  function automatic bit before_in(bit is_max, logic signed [DATA_W-1:0] a,
                                   logic signed [DATA_W-1:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic push_heap(bit is_max, logic signed [DATA_W-1:0] v);
    int unsigned i, p;
    logic signed [DATA_W-1:0] t;
    i = is_max ? lo_cnt : up_cnt;
    if (i >= CAP) return;
    if (is_max) begin lo_heap[i] = v; lo_cnt++; end
    else begin up_heap[i] = v; up_cnt++; end
    while (i > 0) begin
      p = (i - 1) / 2;
      if (is_max) begin
        if (!before_in(1, lo_heap[i], lo_heap[p])) break;
        t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
      end else begin
        if (!before_in(0, up_heap[i], up_heap[p])) break;
        t = up_heap[i]; up_heap[i] = up_heap[p]; up_heap[p] = t;
      end
      i = p;
    end
  endtask

  task automatic pop_heap(bit is_max, output logic signed [DATA_W-1:0] top);
    logic signed [DATA_W-1:0] h[CAP];
    int unsigned n, i, l, c;
    logic signed [DATA_W-1:0] t;
    if (is_max) begin h = lo_heap; n = lo_cnt; end
    else begin h = up_heap; n = up_cnt; end
    top = 0;
    if (n == 0) return;
    top = h[0];
    n--;
    h[0] = h[n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      if (l >= n) break;
      c = l;
      if (l + 1 < n && before_in(is_max, h[l+1], h[l])) c = l + 1;
      if (!before_in(is_max, h[c], h[i])) break;
      t = h[c]; h[c] = h[i]; h[i] = t;
      i = c;
    end
    if (is_max) begin lo_heap = h; lo_cnt = n; end
    else begin up_heap = h; up_cnt = n; end
  endtask

  // expected result of one transaction, updating the predicted store
  task automatic predict_kth(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v,
                             output result_t r);
    int unsigned total;
    r = '0;
    total = lo_cnt + up_cnt + int'(mid_ok);
    case (f)
      FUNC_ADD: begin
        if (total >= CAP) begin
          r.st = STATUS_FULL;
        end else if (!mid_ok) begin
          mid_val = v; mid_ok = 1'b1;
        end else if (v < mid_val) begin
          push_heap(1, v);
          while (lo_cnt > 0 && lo_cnt >= rank_cnt + 1) begin
            push_heap(0, mid_val);
            pop_heap(1, mid_val);
          end
        end else begin
          push_heap(0, v);
        end
      end
      FUNC_GET: begin
        if (!mid_ok || total < rank_cnt + 1) begin
          r.st = STATUS_FEW;
        end else begin
          while (lo_cnt < rank_cnt && up_cnt > 0) begin
            push_heap(1, mid_val);
            pop_heap(0, mid_val);
          end
          rank_cnt++;
          r.kth = mid_val;
        end
      end
      FUNC_CLEAR: begin
        mid_val = 0; mid_ok = 0; lo_cnt = 0; up_cnt = 0; rank_cnt = 0;
      end
      default: ;
    endcase
    r.rnk = rank_cnt[RANK_W-1:0];
  endtask

  // driver: one transaction, random idle before it
  task automatic send_item(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_checked(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v);
    result_t r;
    predict_kth(f, v, r);
    pending_q = {pending_q, r};
    send_item(f, v);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(40)) - 20;
      default: return $signed($urandom);
    endcase
  endfunction

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kth_value_o, rank_o, status_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected kth=%0d rank=%0d status=%0d,",
                      " got kth=%0d rank=%0d status=%0d"},
                     want.kth, want.rnk, want.st, got.kth, got.rnk, got.st);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_recv)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= TIMEOUT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // long receiver hold-off counted in its own process
  task automatic hold_receiver();
    hold_recv = 1'b1;
    repeat (STALL_CAP) @(posedge clk_i);
    hold_recv = 1'b0;
  endtask

  row_t rows[$];

  initial begin
    result_t res;
    int phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    mid_val = 0; mid_ok = 0; lo_cnt = 0; up_cnt = 0; rank_cnt = 0;
    @(posedge clk_i);

    // directed table
    rows = '{
      '{FUNC_GET,   32'sd0,           1, '{32'sd0, 11'd0, STATUS_FEW}},
      '{FUNC_NONE,  -32'sd1,          1, '{32'sd0, 11'd0, STATUS_OK}},
      '{FUNC_ADD,   32'sh7fff_ffff,   1, '{32'sd0, 11'd0, STATUS_OK}},
      '{FUNC_GET,   32'sd0,           1, '{32'sh7fff_ffff, 11'd1, STATUS_OK}},
      '{FUNC_GET,   32'sd0,           1, '{32'sd0, 11'd1, STATUS_FEW}},
      '{FUNC_ADD,   32'sh8000_0000,   0, '0},
      '{FUNC_ADD,   32'sd5,           0, '0},
      '{FUNC_ADD,   32'sd5,           0, '0},
      '{FUNC_ADD,   -32'sd7,          0, '0},
      '{FUNC_GET,   32'sd0,           0, '0},
      '{FUNC_GET,   32'sd0,           0, '0},
      '{FUNC_ADD,   32'sd0,           0, '0},
      '{FUNC_GET,   32'sd0,           0, '0},
      '{FUNC_GET,   32'sd0,           0, '0},
      '{FUNC_GET,   32'sd0,           0, '0},
      '{FUNC_NONE,  32'sd3,           0, '0},
      '{FUNC_CLEAR, 32'sh5555_aaaa,   1, '{32'sd0, 11'd0, STATUS_OK}},
      '{FUNC_GET,   32'sd0,           1, '{32'sd0, 11'd0, STATUS_FEW}},
      '{FUNC_ADD,   -32'sd1,          0, '0},
      '{FUNC_GET,   32'sd0,           1, '{-32'sd1, 11'd1, STATUS_OK}},
      '{FUNC_CLEAR, 32'sd0,           0, '0}
    };
    foreach (rows[i]) begin
      predict_kth(rows[i].func, rows[i].value, res);
      pending_q = {pending_q, (rows[i].typed ? rows[i].res : res)};
      send_item(rows[i].func, rows[i].value);
    end
    drain_results();

    // burst of adds, then walk the ranks up through them
    for (int i = 0; i < 24; i++) send_checked(FUNC_ADD, rand_value());
    for (int i = 0; i < 12; i++) send_checked(FUNC_GET, 0);
    drain_results();
    send_checked(FUNC_CLEAR, 0);

    // random phases with different idle mixes
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 22 : 65) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 22 : 65) : 0;
      if (phase == 1) fork hold_receiver(); join_none
      for (int i = 0; i < 172; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: send_checked(FUNC_ADD, rand_value());
          5, 6, 7: send_checked(FUNC_GET, rand_value());
          8: send_checked($urandom_range(19) == 0 ? FUNC_CLEAR : FUNC_NONE,
                          rand_value());
          default: send_checked(FUNC_GET, 0);
        endcase
      end
      drain_results();
    end

    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
